// ===== design/ptwa_pkg.sv =====
package ptwa_pkg;

  localparam int unsigned AddrW = 48;
  localparam int unsigned TimeW = 32;
  localparam int unsigned ThrW  = 31;
  localparam int unsigned CntOutW = 5;

  localparam logic [ThrW-1:0] ThrReset = 31'd60000;

  localparam logic [2:0] OP_ADD     = 3'd0;
  localparam logic [2:0] OP_REMOVE  = 3'd1;
  localparam logic [2:0] OP_QUERY   = 3'd2;
  localparam logic [2:0] OP_TOUCH   = 3'd3;
  localparam logic [2:0] OP_CLEANUP = 3'd4;

  localparam logic [1:0] ERR_NONE      = 2'd0;
  localparam logic [1:0] ERR_BAD_ADDR  = 2'd1;
  localparam logic [1:0] ERR_FULL      = 2'd2;
  localparam logic [1:0] ERR_NOT_FOUND = 2'd3;

  localparam logic [1:0] ST_UNKNOWN = 2'd0;
  localparam logic [1:0] ST_ONLINE  = 2'd1;
  localparam logic [1:0] ST_STALE   = 2'd2;
  localparam logic [1:0] ST_OFFLINE = 2'd3;

  typedef struct packed {
    logic             valid;
    logic [AddrW-1:0] addr;
    logic [TimeW-1:0] seen;
  } entry_t;

endpackage

// ===== design/peer_table_with_aging.sv =====
// Peer address table with aging.
// Input channel (in_valid_i/in_ready_o) carries one request beat: op_i, peer_address_i,
// now_ms_i and age_limit_i. Output channel (out_valid_o/out_ready_i) returns one
// result beat per request: ok_o, error_code_o, peer_status_o, removed_count_o and
// peer_count_o. The config channel (cfg_valid_i/cfg_ready_o/cfg_data_i) sets the
// stale threshold; write it only while no request is in flight.
// Entries live in a ring of PEER_SLOTS cells that rotates by one cell per cycle
// while a request is being worked on (S_SCAN, S_FILL) past a single compare/update
// head. A request makes one full rotation (S_SCAN) and then posts its result to the
// output register (S_DONE); an add that inserts a new address makes a second rotation
// (S_FILL) before S_DONE. One request is in flight at a time; in_ready_o is high
// again once the result sits in the output register.
// If the receiver stalls, the result is held in the output register and the next
// request may still run; its result then waits until the output register drains.
// Reset empties the table (valid bits cleared at once, no sweep) and sets the
// threshold to 60000 ms.
module peer_table_with_aging
  import ptwa_pkg::*;
#(
  parameter int unsigned PEER_SLOTS = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [2:0]          op_i,
  input  logic [AddrW-1:0]    peer_address_i,
  input  logic [TimeW-1:0]    now_ms_i,
  input  logic [TimeW-1:0]    age_limit_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic                ok_o,
  output logic [1:0]          error_code_o,
  output logic [1:0]          peer_status_o,
  output logic [CntOutW-1:0]  removed_count_o,
  output logic [CntOutW-1:0]  peer_count_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [ThrW-1:0]     cfg_data_i
);

  localparam int unsigned IdxW = (PEER_SLOTS > 1) ? $clog2(PEER_SLOTS) : 1;
  localparam int unsigned CntW = $clog2(PEER_SLOTS + 1);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_FILL = 2'd2;
  localparam logic [1:0] S_DONE = 2'd3;

  logic [1:0]       phase_q;
  logic [IdxW-1:0]  idx_q;
  logic             last_step;
  logic             shift;

  logic [2:0]       op_q;
  logic [AddrW-1:0] addr_q;
  logic [TimeW-1:0] now_q;
  logic [TimeW-1:0] limit_q;
  logic [ThrW-1:0]  thr_q;

  logic             found_q, found_d;
  logic             free_q, free_d;
  logic             ins_q, ins_d;
  logic [1:0]       status_q, status_d;
  logic [CntW-1:0]  rm_q, rm_d;
  logic [CntW-1:0]  count_q, count_d;

  logic             bad_addr;
  logic             accept;
  logic             out_load;

  entry_t           ring [PEER_SLOTS];
  entry_t           head;
  entry_t           cur;
  logic [TimeW-1:0] age;
  logic             match;
  logic [PEER_SLOTS-1:0] valid_vec;

  logic             out_valid_q;
  logic             ok_q;
  logic [1:0]       err_q;
  logic [1:0]       pst_q;
  logic [CntW-1:0]  rmo_q;
  logic [CntW-1:0]  cnto_q;

  logic             res_ok;
  logic [1:0]       res_err;
  logic [1:0]       res_st;
  logic [CntW-1:0]  res_rm;

  assign shift     = (phase_q == S_SCAN) || (phase_q == S_FILL);
  assign last_step = (idx_q == IdxW'(PEER_SLOTS - 1));
  assign bad_addr  = (~|addr_q) || (&addr_q);

  for (genvar k = 0; k < PEER_SLOTS; k++) begin : g_cell
    entry_t in_k;
    if (k == PEER_SLOTS - 1) begin : g_tail
      assign in_k = head;
    end else begin : g_mid
      assign in_k = ring[k+1];
    end
    ptwa_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .shift_i (shift),
      .entry_i (in_k),
      .entry_o (ring[k])
    );
    assign valid_vec[k] = ring[k].valid;
  end

  assign cur   = ring[0];
  assign age   = now_q - cur.seen;
  assign match = cur.valid && (cur.addr == addr_q);

  always_comb begin
    head     = cur;
    found_d  = found_q;
    free_d   = free_q;
    ins_d    = ins_q;
    status_d = status_q;
    rm_d     = rm_q;
    count_d  = count_q;
    if (accept) begin
      found_d  = 1'b0;
      free_d   = 1'b0;
      ins_d    = 1'b0;
      status_d = ST_UNKNOWN;
      rm_d     = '0;
    end else if (phase_q == S_SCAN) begin
      case (op_q)
        OP_ADD: begin
          if (match) found_d = 1'b1;
          if (!cur.valid) free_d = 1'b1;
        end
        OP_REMOVE: begin
          if (match) begin
            head.valid = 1'b0;
            found_d    = 1'b1;
            count_d    = count_q - CntW'(1);
          end
        end
        OP_QUERY: begin
          if (match) begin
            found_d = 1'b1;
            if (age < {1'b0, thr_q}) status_d = ST_ONLINE;
            else if (age < {thr_q, 1'b0}) status_d = ST_STALE;
            else status_d = ST_OFFLINE;
          end
        end
        OP_TOUCH: begin
          if (match) begin
            head.seen = now_q;
            found_d   = 1'b1;
          end
        end
        OP_CLEANUP: begin
          if (cur.valid && (age > limit_q)) begin
            head.valid = 1'b0;
            rm_d       = rm_q + CntW'(1);
            count_d    = count_q - CntW'(1);
          end
        end
        default: ;
      endcase
    end else if (phase_q == S_FILL) begin
      if (!cur.valid && !ins_q) begin
        head.valid = 1'b1;
        head.addr  = addr_q;
        head.seen  = now_q;
        ins_d      = 1'b1;
        count_d    = count_q + CntW'(1);
      end
    end
  end

  always_comb begin
    res_ok  = 1'b0;
    res_err = ERR_NONE;
    res_st  = ST_UNKNOWN;
    res_rm  = '0;
    case (op_q)
      OP_ADD: begin
        if (bad_addr) res_err = ERR_BAD_ADDR;
        else if (found_q) res_ok = 1'b1;
        else if (!free_q) res_err = ERR_FULL;
        else res_ok = 1'b1;
      end
      OP_REMOVE: begin
        res_ok  = found_q;
        res_err = found_q ? ERR_NONE : ERR_NOT_FOUND;
        res_rm  = found_q ? CntW'(1) : '0;
      end
      OP_QUERY: begin
        res_ok  = found_q;
        res_err = found_q ? ERR_NONE : ERR_NOT_FOUND;
        res_st  = found_q ? status_q : ST_UNKNOWN;
      end
      OP_TOUCH: begin
        res_ok  = found_q;
        res_err = found_q ? ERR_NONE : ERR_NOT_FOUND;
      end
      OP_CLEANUP: begin
        res_ok = 1'b1;
        res_rm = rm_q;
      end
      default: ;
    endcase
  end

  assign in_ready_o = (phase_q == S_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign out_load   = (phase_q == S_DONE) && (!out_valid_q || out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= S_IDLE;
      idx_q    <= '0;
      found_q  <= 1'b0;
      free_q   <= 1'b0;
      ins_q    <= 1'b0;
      status_q <= ST_UNKNOWN;
      rm_q     <= '0;
      count_q  <= '0;
    end else begin
      found_q  <= found_d;
      free_q   <= free_d;
      ins_q    <= ins_d;
      status_q <= status_d;
      rm_q     <= rm_d;
      count_q  <= count_d;
      case (phase_q)
        S_IDLE: begin
          if (accept) begin
            phase_q <= S_SCAN;
            idx_q   <= '0;
          end
        end
        S_SCAN: begin
          if (last_step) begin
            idx_q <= '0;
            if (op_q == OP_ADD && !bad_addr && !found_d && free_d) phase_q <= S_FILL;
            else phase_q <= S_DONE;
          end else begin
            idx_q <= idx_q + IdxW'(1);
          end
        end
        S_FILL: begin
          if (last_step) begin
            idx_q   <= '0;
            phase_q <= S_DONE;
          end else begin
            idx_q <= idx_q + IdxW'(1);
          end
        end
        S_DONE: begin
          if (out_load) phase_q <= S_IDLE;
        end
        default: phase_q <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q    <= op_i;
      addr_q  <= peer_address_i;
      now_q   <= now_ms_i;
      limit_q <= age_limit_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= ThrReset;
    end else if (cfg_valid_i) begin
      thr_q <= cfg_data_i;
    end
  end

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      ok_q   <= res_ok;
      err_q  <= res_err;
      pst_q  <= res_st;
      rmo_q  <= res_rm;
      cnto_q <= count_q;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign ok_o            = ok_q;
  assign error_code_o    = err_q;
  assign peer_status_o   = pst_q;
  assign removed_count_o = CntOutW'(rmo_q);
  assign peer_count_o    = CntOutW'(cnto_q);

`ifndef ASSERT_OFF
  a_count_matches: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == S_IDLE) |-> ($countones(valid_vec) == int'(count_q)))
    else $error("peer count disagrees with valid cells");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    int'(count_q) <= int'(PEER_SLOTS))
    else $error("peer count above table size");

  a_fill_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == S_FILL) |-> (free_q && !found_q && !bad_addr && op_q == OP_ADD))
    else $error("insert pass without a free slot or with a duplicate");

  a_insert_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == S_DONE && op_q == OP_ADD && !bad_addr && !found_q && free_q) |-> ins_q)
    else $error("add finished without inserting");

  a_ring_home: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == S_DONE || phase_q == S_IDLE) |-> (idx_q == '0))
    else $error("ring left mid rotation");
`endif

endmodule

// ===== design/ptwa_cell.sv =====
module ptwa_cell
  import ptwa_pkg::*;
(
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   shift_i,
  input  entry_t entry_i,
  output entry_t entry_o
);

  logic             valid_q;
  logic [AddrW-1:0] addr_q;
  logic [TimeW-1:0] seen_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (shift_i) begin
      valid_q <= entry_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (shift_i) begin
      addr_q <= entry_i.addr;
      seen_q <= entry_i.seen;
    end
  end

  assign entry_o = '{valid: valid_q, addr: addr_q, seen: seen_q};

endmodule
